>>> rtl/core/ewkb_hex_srid_strip_decoder_macros.svh
// Assertion macros for the EWKB hex decoder with SRID strip.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef EWKB_HEX_SRID_STRIP_DECODER_MACROS_SVH
`define EWKB_HEX_SRID_STRIP_DECODER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define EHSSD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define EHSSD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define EHSSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ehssd_pkg.sv
// Shared types and constants for the EWKB hex decoder with SRID strip.
// No dependencies.
package ehssd_pkg;

	localparam int unsigned HDR_LEN       = 5;
	localparam int unsigned SRID_END      = 9;
	localparam logic [7:0]  SRID_FLAG     = 8'h20;
	localparam int unsigned QUEUE_DEPTH_D = 4;

	// One queued request: up to HDR_LEN bytes to emit in order, with an end mark.
	// A count of zero with eob set is a bare end marker.
	typedef struct packed {
		logic [HDR_LEN-1:0][7:0] bytes_v;
		logic [2:0]              count;
		logic                    eob;
	} ehssd_cmd_t;

endpackage

>>> rtl/core/ehssd_front.sv
// Front part: decodes hex characters, pairs nibbles, holds the header and
// classifies each byte into a queued request. Depends on ehssd_pkg.
module ehssd_front
	import ehssd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] hex_char,
	input  logic       final_char,
	output logic       cmd_gen,
	output ehssd_cmd_t cmd
);

	logic       low_next_q;
	logic [3:0] pend_q;
	logic [3:0] cnt_q;
	logic       drop_q;
	logic [7:0] hold_q [HDR_LEN-1];

	logic [3:0] nib;
	logic [7:0] byte_val;
	logic       byte_done;
	logic       strip;
	logic       sel_low;

	function automatic logic [3:0] nib_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30;
		end else if (c inside {[8'h41:8'h46]}) begin
			d = c - 8'h37;
		end else if (c inside {[8'h61:8'h66]}) begin
			d = c - 8'h57;
		end
		return d[3:0];
	endfunction

	always_comb begin
		nib       = nib_of(hex_char);
		byte_val  = low_next_q ? {pend_q, nib} : {nib, 4'h0};
		byte_done = low_next_q | final_char;
		sel_low   = (hold_q[0] == 8'h00);
		strip     = sel_low ? ((hold_q[1] & SRID_FLAG) != 8'h00)
		                    : ((byte_val & SRID_FLAG) != 8'h00);

		for (int k = 0; k < HDR_LEN - 1; k++) begin
			cmd.bytes_v[k] = hold_q[k];
		end
		cmd.bytes_v[HDR_LEN-1] = byte_val;
		cmd.count = 3'd0;
		cmd.eob   = final_char;

		if (byte_done) begin
			if (cnt_q < 4'(HDR_LEN - 1)) begin
				// Short blob: flush what is held plus this byte.
				if (final_char) begin
					cmd.bytes_v[cnt_q[1:0]] = byte_val;
					cmd.count = {1'b0, cnt_q[1:0]} + 3'd1;
				end
			end else if (cnt_q == 4'(HDR_LEN - 1)) begin
				// Header complete: clear the SRID flag when set.
				if (strip) begin
					if (sel_low) begin
						cmd.bytes_v[1] = hold_q[1] & ~SRID_FLAG;
					end else begin
						cmd.bytes_v[HDR_LEN-1] = byte_val & ~SRID_FLAG;
					end
				end
				cmd.count = 3'(HDR_LEN);
			end else if (cnt_q < 4'(SRID_END)) begin
				if (!drop_q) begin
					cmd.bytes_v[0] = byte_val;
					cmd.count = 3'd1;
				end
			end else begin
				cmd.bytes_v[0] = byte_val;
				cmd.count = 3'd1;
			end
		end
		cmd_gen = final_char | (cmd.count != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_next_q <= 1'b0;
			pend_q     <= 4'h0;
			cnt_q      <= 4'd0;
			drop_q     <= 1'b0;
		end else if (accept) begin
			if (final_char) begin
				low_next_q <= 1'b0;
				pend_q     <= 4'h0;
				cnt_q      <= 4'd0;
				drop_q     <= 1'b0;
			end else if (low_next_q) begin
				low_next_q <= 1'b0;
				if (cnt_q < 4'(SRID_END)) begin
					cnt_q <= cnt_q + 4'd1;
				end
				if (cnt_q == 4'(HDR_LEN - 1) && strip) begin
					drop_q <= 1'b1;
				end
			end else begin
				pend_q     <= nib;
				low_next_q <= 1'b1;
			end
		end
	end

	// Header bytes; only read at entries written earlier in the same string.
	always_ff @(posedge clk) begin
		if (accept && byte_done && cnt_q < 4'(HDR_LEN - 1)) begin
			hold_q[cnt_q[1:0]] <= byte_val;
		end
	end

endmodule

>>> rtl/core/ehssd_queue.sv
// Short request queue between front and back parts.
// Depends on ehssd_pkg and the assertion macro header.
`include "ewkb_hex_srid_strip_decoder_macros.svh"
module ehssd_queue
	import ehssd_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_D
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ehssd_cmd_t push_data,
	output logic       full,
	input  logic       pop,
	output ehssd_cmd_t pop_data,
	output logic       nonempty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ehssd_cmd_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`EHSSD_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(DEPTH), "queue count beyond depth")
	`EHSSD_ASSERT_IMPL(a_no_push_full, push, !full, "push into full queue")
	`EHSSD_ASSERT_NEXT(a_pop_count, pop && !push, cnt_q == $past(cnt_q) - 1'b1,
		"queue count did not drop after pop")

endmodule

>>> rtl/core/ehssd_back.sv
// Back part: expands queued requests into result beats, one per cycle when
// not stalled, through an output register. Needs ehssd_pkg and macro header.
`include "ewkb_hex_srid_strip_decoder_macros.svh"
module ehssd_back
	import ehssd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  ehssd_cmd_t cmd,
	output logic       cmd_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] wkb_byte,
	output logic       byte_present,
	output logic       end_of_blob
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       present_q;
	logic       eob_q;
	logic       load;
	logic       last;
	logic [7:0] beat_byte;

	always_comb begin
		load      = cmd_valid && (!out_valid_q || !out_stall);
		last      = (cmd.count == 3'd0) || (idx_q == cmd.count - 3'd1);
		beat_byte = (cmd.count == 3'd0) ? 8'h00 : cmd.bytes_v[idx_q];
		cmd_pop   = load && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= last ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q    <= beat_byte;
			present_q <= (cmd.count != 3'd0);
			eob_q     <= cmd.eob && last;
		end
	end

	assign out_valid    = out_valid_q;
	assign wkb_byte     = byte_q;
	assign byte_present = present_q;
	assign end_of_blob  = eob_q;

	`EHSSD_ASSERT_ALWAYS(a_idx_bound, idx_q < 3'(HDR_LEN), "beat index past header length")
	`EHSSD_ASSERT_IMPL(a_idx_in_cmd, cmd_valid && cmd.count != 3'd0, idx_q < cmd.count,
		"beat index beyond request count")
	`EHSSD_ASSERT_NEXT(a_out_hold, out_valid_q && out_stall,
		out_valid_q && byte_q == $past(byte_q), "stalled output changed")

endmodule

>>> rtl/core/ewkb_hex_srid_strip_decoder.sv
// Top level of the EWKB hex decoder with SRID strip.
// Depends on ehssd_pkg, ehssd_front, ehssd_queue and ehssd_back.
//
// Usage:
//  - Input channel (in_valid / in_stall): one hex text character per request,
//    final_char marks the last character of a string. A request is taken at
//    a rising edge with in_valid high and in_stall low.
//  - Output channel (out_valid / out_stall): one decoded byte per request,
//    byte_present low marks a bare end marker, end_of_blob marks the last
//    result of a string.
//  - Throughput: one character per cycle while in_stall is low. The back part
//    drives one result per cycle while out_stall is low, so a five-byte header
//    burst drains while the request queue (QUEUE_DEPTH entries) absorbs more.
//  - Path: the first result caused by a character is written to the queue,
//    then loaded into the output register, where it becomes valid.
//  - in_stall rises only while the request queue is full.
//  - When out_stall is high, hold the output payload; the front keeps taking
//    characters until the queue fills.
//  - Reset: clears the nibble pairing, byte count, SRID drop flag, the queue
//    and the output valid. The header store needs no clearing.
module ewkb_hex_srid_strip_decoder
	import ehssd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_D
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] hex_char,
	input  logic       final_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] wkb_byte,
	output logic       byte_present,
	output logic       end_of_blob
);

	logic       accept;
	logic       cmd_gen;
	logic       q_full;
	logic       q_nonempty;
	logic       q_pop;
	ehssd_cmd_t front_cmd;
	ehssd_cmd_t back_cmd;

	// Stall the input only while no request slot is free.
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	ehssd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.hex_char   (hex_char),
		.final_char (final_char),
		.cmd_gen    (cmd_gen),
		.cmd        (front_cmd)
	);

	// Push only characters that produce output or end a string.
	ehssd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && cmd_gen),
		.push_data (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (back_cmd),
		.nonempty  (q_nonempty)
	);

	ehssd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_nonempty),
		.cmd          (back_cmd),
		.cmd_pop      (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.wkb_byte     (wkb_byte),
		.byte_present (byte_present),
		.end_of_blob  (end_of_blob)
	);

endmodule
